[rtl/cbq_pkg.sv]
package cbq_pkg;

  // Stream and register widths.
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 54;
  localparam int unsigned NUM_CFG_REGS = 3;

  // Coefficient fields inside one section register, each signed Q2.16.
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned G_LSB    = 36;
  localparam int unsigned A1_LSB   = 18;
  localparam int unsigned A2_LSB   = 0;

  // Internal sample format: signed 40 bits with 16 fraction bits.
  localparam int unsigned DATA_W   = 40;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned HALF_W   = 20;
  localparam int unsigned MOP_W    = HALF_W + 1;
  localparam int unsigned PROD_W   = COEF_W + MOP_W;
  localparam int unsigned ACC_W    = DATA_W + FRAC_W;

  localparam int unsigned SECTION_COUNT_DEF = 3;
  localparam int unsigned STEP_W            = 4;

  localparam logic [CFG_DATA_W-1:0] COEF_RESET [NUM_CFG_REGS] = '{
    54'd126001890252332,
    54'd110406241917924,
    54'd103054991720546
  };

  typedef enum logic [1:0] {
    COEF_G  = 2'd0,
    COEF_A1 = 2'd1,
    COEF_A2 = 2'd2
  } coef_sel_e;

  typedef enum logic [1:0] {
    OPND_X  = 2'd0,
    OPND_Y1 = 2'd1,
    OPND_Y2 = 2'd2
  } opnd_sel_e;

  typedef enum logic [2:0] {
    ACC_NONE = 3'd0,
    ACC_LOAD = 3'd1,
    ACC_ADD  = 3'd2,
    ACC_SUB  = 3'd3,
    ACC_NUM  = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic      load_x;
    coef_sel_e coef_sel;
    opnd_sel_e opnd_sel;
    logic      mul_hi;
    acc_op_e   acc_op;
    logic      acc_sh;
    logic      s_load;
    logic      hist_update;
    logic      out_load;
  } dp_cmd_t;

endpackage

[rtl/cascaded_biquad_lowpass.sv]
// Cascaded low-pass filter: SECTION_COUNT second-order IIR sections in
// direct form I, computed in fixed point on one shared 18 x 21 multiplier.
// Samples enter on the s_axis channel, one unsigned 16-bit sample per beat,
// and leave on the m_axis channel with the saturated result in tdata and a
// clip flag in tuser. The cfg channel writes the per-section coefficient
// registers (gain, a1, a2, each signed Q2.16); it is always ready and must
// only be used while no sample is in flight.
// Each section runs these steps on the multiplier and accumulator: two
// half-width products for the gain and one more to add in the upper one,
// a rounding step, two each for a1 and a2, one to subtract the last a2
// product, and a history update. A sample runs through every section in
// turn before its result is loaded into the output register, and a new
// sample is accepted only after the previous one has left its last section.
// The output register holds a finished result while the next sample is
// already accepted and filtered. If the receiver stalls, the block finishes
// the next sample and then waits with s_axis_tready low until the output
// register frees up. Reset clears all filter history, loads the default
// coefficients and leaves both streams empty.
module cascaded_biquad_lowpass #(
  parameter int unsigned SECTION_COUNT = cbq_pkg::SECTION_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream; tdata: sample_in[15:0].
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cbq_pkg::SAMPLE_W-1:0]     s_axis_tdata,
  // Output stream; tdata: sample_out[15:0]; tuser: clipped[0].
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [cbq_pkg::SAMPLE_W-1:0]     m_axis_tdata,
  output logic [0:0]                       m_axis_tuser,
  // Coefficient register writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cbq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import cbq_pkg::*;

  localparam int unsigned SecW = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;

  dp_cmd_t         cmd;
  logic [SecW-1:0] sec;
  logic            cfg_we;

  // Registers accept a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  cbq_ctrl #(
    .SECTION_COUNT(SECTION_COUNT),
    .SecW         (SecW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sec_o      (sec)
  );

  cbq_datapath #(
    .SECTION_COUNT(SECTION_COUNT),
    .SecW         (SecW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sec_i      (sec),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (s_axis_tdata),
    .sample_o   (m_axis_tdata),
    .clipped_o  (m_axis_tuser[0])
  );

  // A clipped result is always pinned to one of the two rails.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      ((m_axis_tdata == '0) || (m_axis_tdata == '1)))
    else $error("clipped result is not saturated");

  // A freshly accepted sample cannot produce a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !cmd.out_load)
    else $error("result loaded right after a sample was accepted");

  // The section counter never walks past the last section.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec <= SecW'(SECTION_COUNT - 1))
    else $error("section index out of range");

  // History is only updated while a sample is being filtered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.hist_update |-> !s_axis_tready)
    else $error("history update while idle");

endmodule

[rtl/cbq_ctrl.sv]
module cbq_ctrl #(
  parameter int unsigned SECTION_COUNT = cbq_pkg::SECTION_COUNT_DEF,
  parameter int unsigned SecW = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cbq_pkg::dp_cmd_t cmd_o,
  output logic [SecW-1:0]  sec_o
);
  import cbq_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRun    = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  localparam logic [STEP_W-1:0] StepGLo  = 4'd0;
  localparam logic [STEP_W-1:0] StepGHi  = 4'd1;
  localparam logic [STEP_W-1:0] StepGAdd = 4'd2;
  localparam logic [STEP_W-1:0] StepRndS = 4'd3;
  localparam logic [STEP_W-1:0] StepA1Lo = 4'd4;
  localparam logic [STEP_W-1:0] StepA1Hi = 4'd5;
  localparam logic [STEP_W-1:0] StepA2Lo = 4'd6;
  localparam logic [STEP_W-1:0] StepA2Hi = 4'd7;
  localparam logic [STEP_W-1:0] StepLast = 4'd8;
  localparam logic [STEP_W-1:0] StepHist = 4'd9;

  localparam logic [SecW-1:0] LastSec = SecW'(SECTION_COUNT - 1);

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              accept;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle) || ((state_q == StFinish) && out_free);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign sec_o       = sec_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sec_d       = sec_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_x = 1'b1;
          state_d      = StRun;
          step_d       = StepGLo;
          sec_d        = '0;
        end
      end
      StRun: begin
        step_d = step_q + STEP_W'(1);
        unique case (step_q)
          StepGLo: begin
            cmd_o.coef_sel = COEF_G;
            cmd_o.opnd_sel = OPND_X;
          end
          StepGHi: begin
            cmd_o.coef_sel = COEF_G;
            cmd_o.opnd_sel = OPND_X;
            cmd_o.mul_hi   = 1'b1;
            cmd_o.acc_op   = ACC_LOAD;
          end
          StepGAdd: begin
            cmd_o.acc_op = ACC_ADD;
            cmd_o.acc_sh = 1'b1;
          end
          StepRndS: begin
            cmd_o.s_load = 1'b1;
          end
          StepA1Lo: begin
            cmd_o.coef_sel = COEF_A1;
            cmd_o.opnd_sel = OPND_Y1;
            cmd_o.acc_op   = ACC_NUM;
          end
          StepA1Hi: begin
            cmd_o.coef_sel = COEF_A1;
            cmd_o.opnd_sel = OPND_Y1;
            cmd_o.mul_hi   = 1'b1;
            cmd_o.acc_op   = ACC_SUB;
          end
          StepA2Lo: begin
            cmd_o.coef_sel = COEF_A2;
            cmd_o.opnd_sel = OPND_Y2;
            cmd_o.acc_op   = ACC_SUB;
            cmd_o.acc_sh   = 1'b1;
          end
          StepA2Hi: begin
            cmd_o.coef_sel = COEF_A2;
            cmd_o.opnd_sel = OPND_Y2;
            cmd_o.mul_hi   = 1'b1;
            cmd_o.acc_op   = ACC_SUB;
          end
          StepLast: begin
            cmd_o.acc_op = ACC_SUB;
            cmd_o.acc_sh = 1'b1;
          end
          StepHist: begin
            cmd_o.hist_update = 1'b1;
            step_d            = StepGLo;
            if (sec_q == LastSec) begin
              state_d = StFinish;
            end else begin
              sec_d = sec_q + SecW'(1);
            end
          end
          default: begin
            step_d  = StepGLo;
            state_d = StIdle;
          end
        endcase
      end
      StFinish: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          if (accept) begin
            cmd_o.load_x = 1'b1;
            state_d      = StRun;
            step_d       = StepGLo;
            sec_d        = '0;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= StepGLo;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/cbq_datapath.sv]
module cbq_datapath #(
  parameter int unsigned SECTION_COUNT = cbq_pkg::SECTION_COUNT_DEF,
  parameter int unsigned SecW = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cbq_pkg::dp_cmd_t                 cmd_i,
  input  logic [SecW-1:0]                  sec_i,
  input  logic                             cfg_we_i,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cbq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [cbq_pkg::SAMPLE_W-1:0]     sample_i,
  output logic [cbq_pkg::SAMPLE_W-1:0]     sample_o,
  output logic                             clipped_o
);
  import cbq_pkg::*;

  logic [CFG_DATA_W-1:0] coef_q [SECTION_COUNT];
  logic [DATA_W-1:0]     s1_q [SECTION_COUNT];
  logic [DATA_W-1:0]     s2_q [SECTION_COUNT];
  logic [DATA_W-1:0]     y1_q [SECTION_COUNT];
  logic [DATA_W-1:0]     y2_q [SECTION_COUNT];

  logic [DATA_W-1:0]     x_q, s_q;
  logic [ACC_W-1:0]      acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SAMPLE_W-1:0]   sample_q;
  logic                  clipped_q;

  logic [CFG_DATA_W-1:0] coef_cur;
  logic signed [COEF_W-1:0] mul_a;
  logic signed [MOP_W-1:0]  mul_b;
  logic [DATA_W-1:0]     opnd;
  logic signed [PROD_W-1:0] prod_d;
  logic [ACC_W-1:0]      prod_ext, addend;
  logic [ACC_W-1:0]      rnd_sum;
  logic [DATA_W-1:0]     rnd;
  logic [DATA_W-1:0]     num;
  logic [SAMPLE_W-1:0]   sat_sample;
  logic                  sat_clip;

  // Coefficient registers: the first sections are writable, any extra ones
  // repeat the reset values of the first three and stay fixed.
  for (genvar i = 0; i < SECTION_COUNT; i++) begin : g_sec
    if (i < NUM_CFG_REGS) begin : g_wr
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          coef_q[i] <= COEF_RESET[i];
        end else if (cfg_we_i && (cfg_index_i == CFG_IDX_W'(i))) begin
          coef_q[i] <= cfg_data_i;
        end
      end
    end else begin : g_fixed
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          coef_q[i] <= COEF_RESET[i % NUM_CFG_REGS];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_q[i] <= '0;
        s2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end else if (cmd_i.hist_update && (sec_i == SecW'(i))) begin
        s2_q[i] <= s1_q[i];
        s1_q[i] <= s_q;
        y2_q[i] <= y1_q[i];
        y1_q[i] <= rnd;
      end
    end
  end

  assign coef_cur = coef_q[sec_i];

  always_comb begin
    case (cmd_i.coef_sel)
      COEF_G:  mul_a = coef_cur[G_LSB  +: COEF_W];
      COEF_A1: mul_a = coef_cur[A1_LSB +: COEF_W];
      default: mul_a = coef_cur[A2_LSB +: COEF_W];
    endcase
    case (cmd_i.opnd_sel)
      OPND_X:  opnd = x_q;
      OPND_Y1: opnd = y1_q[sec_i];
      default: opnd = y2_q[sec_i];
    endcase
  end

  // The 40-bit operand is multiplied in two halves: an unsigned low half
  // and a signed high half weighted by 2^20.
  assign mul_b  = cmd_i.mul_hi ? {opnd[DATA_W-1], opnd[DATA_W-1 -: HALF_W]}
                               : {1'b0, opnd[HALF_W-1:0]};
  assign prod_d = mul_a * mul_b;

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign addend   = cmd_i.acc_sh ? {prod_ext[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}} : prod_ext;

  // Round half up, floor shift by the fraction width, wrap to 40 bits.
  assign rnd_sum = acc_q + (ACC_W'(1) << (FRAC_W - 1));
  assign rnd     = rnd_sum[ACC_W-1:FRAC_W];

  assign num = s_q + {s1_q[sec_i][DATA_W-2:0], 1'b0} + s2_q[sec_i];

  always_comb begin
    if (x_q[DATA_W-1]) begin
      sat_sample = '0;
      sat_clip   = 1'b1;
    end else if (x_q[DATA_W-2:FRAC_W+SAMPLE_W] != '0) begin
      sat_sample = '1;
      sat_clip   = 1'b1;
    end else begin
      sat_sample = x_q[FRAC_W +: SAMPLE_W];
      sat_clip   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= addend;
      ACC_ADD:  acc_q <= acc_q + addend;
      ACC_SUB:  acc_q <= acc_q - addend;
      ACC_NUM:  acc_q <= {num, {FRAC_W{1'b0}}};
      default:  acc_q <= acc_q;
    endcase
    if (cmd_i.s_load) begin
      s_q <= rnd;
    end
    if (cmd_i.load_x) begin
      x_q <= {{(DATA_W-SAMPLE_W-FRAC_W){1'b0}}, sample_i, {FRAC_W{1'b0}}};
    end else if (cmd_i.hist_update) begin
      x_q <= rnd;
    end
    if (cmd_i.out_load) begin
      sample_q  <= sat_sample;
      clipped_q <= sat_clip;
    end
  end

  assign sample_o  = sample_q;
  assign clipped_o = clipped_q;

endmodule

[verif/cascaded_biquad_lowpass_tb.sv]
`timescale 1ns / 1ps

module cascaded_biquad_lowpass_tb;
  import cbq_pkg::*;

  // The filter has three sections.
  localparam int unsigned SECTIONS = SECTION_COUNT_DEF;
  localparam int unsigned LATENCY  = 10 * SECTIONS + 1;

  // Coefficient register indexes. The fourth index selects no register,
  // and the block must ignore writes to it.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTION0 = 2'd0,
    REG_SECTION1 = 2'd1,
    REG_SECTION2 = 2'd2,
    REG_SPARE    = 2'd3
  } cfg_reg_e;

  // Internal samples are signed 40-bit Q.16 values. The predictor works in
  // 64 bits, which holds every product and accumulator sum exactly.
  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [63:0]       wide_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic                clipped;
  } filtered_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic                drain_first;  // hold this beat until all results are back
  } adc_item_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  cascaded_biquad_lowpass DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the coefficient registers and the filter history.
  logic [CFG_DATA_W-1:0] coef_shadow [SECTIONS];
  q16_t                  scaled_hist [SECTIONS][2];
  q16_t                  filt_hist   [SECTIONS][2];

  adc_item_t adc_q[$];        // samples waiting to be sent
  filtered_t filtered_q[$];   // expected filter outputs, oldest first
  adc_item_t adc_beat;
  filtered_t want;

  int unsigned samples_queued = 0;
  int unsigned samples_taken  = 0;
  int unsigned results_seen   = 0;
  int unsigned err_count      = 0;
  int unsigned rx_hold        = 0;
  int          walk_level     = 32768;
  bit          tx_idle_en     = 1'b1;
  bit          rx_idle_en     = 1'b1;

  // Round half up and drop the 16 low fraction bits with a floor shift,
  // then wrap to 40 bits.
  function automatic q16_t round_q16(wide_t acc);
    wide_t v;
    v = acc + wide_t'(32768);
    return v[FRAC_W +: DATA_W];
  endfunction

  // Runs one sample through all sections and advances the history.
  function automatic filtered_t filter_sample(logic [SAMPLE_W-1:0] smp);
    filtered_t          r;
    q16_t               x;
    q16_t               s;
    q16_t               y;
    logic signed [17:0] g;
    logic signed [17:0] a1;
    logic signed [17:0] a2;
    wide_t              num;
    wide_t              acc;
    x = q16_t'({smp, 16'h0000});
    y = '0;
    for (int i = 0; i < SECTIONS; i++) begin
      g  = coef_shadow[i][G_LSB +: COEF_W];
      a1 = coef_shadow[i][A1_LSB +: COEF_W];
      a2 = coef_shadow[i][A2_LSB +: COEF_W];
      s  = round_q16(wide_t'(g) * wide_t'(x));
      // Fixed numerator 1, 2, 1 on the scaled inputs, then the feedback taps.
      num = wide_t'(s) + (wide_t'(scaled_hist[i][0]) <<< 1) + wide_t'(scaled_hist[i][1]);
      acc = (num <<< FRAC_W) - wide_t'(a1) * wide_t'(filt_hist[i][0])
            - wide_t'(a2) * wide_t'(filt_hist[i][1]);
      y = round_q16(acc);
      scaled_hist[i][1] = scaled_hist[i][0];
      scaled_hist[i][0] = s;
      filt_hist[i][1]   = filt_hist[i][0];
      filt_hist[i][0]   = y;
      x = y;
    end
    // Negative outputs clamp to zero, integer parts above 16 bits to full scale.
    if (y[DATA_W-1]) begin
      r = '{sample_out: '0, clipped: 1'b1};
    end else if (y[DATA_W-1:FRAC_W+SAMPLE_W] != '0) begin
      r = '{sample_out: '1, clipped: 1'b1};
    end else begin
      r = '{sample_out: y[FRAC_W +: SAMPLE_W], clipped: 1'b0};
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] exp_val);
    $display("ERROR: result %0d: %s: got %h, expected %h", results_seen, what, got, exp_val);
    err_count++;
  endtask

  // Sender. A beat is predicted at the edge that accepts it, so the filter
  // state seen by the predictor always matches the order of the stream.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        filtered_q.push_back(filter_sample(s_axis_tdata));
        samples_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (adc_q.size() != 0 && !(tx_idle_en && $urandom_range(99) < 9) &&
            !(adc_q[0].drain_first && filtered_q.size() != 0)) begin
          adc_beat = adc_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= adc_beat.level;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Stalls come in runs, sometimes long enough that the block
  // fills its output register and backs up the input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch("beat with no result expected", m_axis_tdata, '0);
        end else begin
          want = filtered_q.pop_front();
          if (m_axis_tdata !== want.sample_out)
            report_mismatch("sample_out", m_axis_tdata, want.sample_out);
          if (m_axis_tuser[0] !== want.clipped)
            report_mismatch("clipped", SAMPLE_W'(m_axis_tuser[0]), SAMPLE_W'(want.clipped));
        end
        results_seen++;
      end
      if (rx_hold == 0 && rx_idle_en && $urandom_range(99) == 0)
        rx_hold = ($urandom_range(3) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
      m_axis_tready <= (rx_hold == 0);
      if (rx_hold != 0)
        rx_hold--;
    end
  end

  task automatic queue_sample(input logic [SAMPLE_W-1:0] level, input bit drain_first);
    adc_q.push_back('{level: level, drain_first: drain_first});
    samples_queued++;
  endtask

  // Mix of full-scale extremes, white noise and a slowly wandering level
  // that looks like a real converter signal.
  function automatic logic [SAMPLE_W-1:0] next_level();
    int step;
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return SAMPLE_W'($urandom);
      default: begin
        step = $urandom_range(2000);
        walk_level += step - 1000;
        if (walk_level < 0)
          walk_level = 0;
        if (walk_level > 65535)
          walk_level = 65535;
        return walk_level[SAMPLE_W-1:0];
      end
    endcase
  endfunction

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++)
      queue_sample(next_level(), $urandom_range(199) == 0);
  endtask

  // Waits until every queued sample is accepted and its result checked,
  // then lets the pipeline settle before the next register write.
  task automatic wait_drained();
    while (samples_taken != samples_queued || filtered_q.size() != 0)
      @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
  endtask

  // One register write; the caller lowers cfg_valid_i after its last write
  // so that back-to-back writes keep valid high.
  task automatic write_coef(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_CFG_REGS)
      coef_shadow[idx] = val;
  endtask

  // Writes the same gain, a1 and a2 to every section, plus a write to the
  // unused index that must change nothing.
  task automatic program_sections(input logic [17:0] g, input logic [17:0] a1,
                                  input logic [17:0] a2);
    for (int i = 0; i < SECTIONS; i++)
      write_coef(cfg_reg_e'(i), {g, a1, a2});
    write_coef(REG_SPARE, CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    foreach (coef_shadow[i]) begin
      coef_shadow[i] = COEF_RESET[i];
      scaled_hist[i] = '{default: '0};
      filt_hist[i]   = '{default: '0};
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default low-pass coefficients: full-scale steps, mid-scale codes,
    // single-bit patterns and a long full-scale run to settle the DC gain.
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'h8000, 1'b0);
    queue_sample(16'h7FFF, 1'b0);
    queue_sample(16'h0001, 1'b0);
    queue_sample(16'hFFFE, 1'b0);
    queue_sample(16'h5555, 1'b0);
    queue_sample(16'hAAAA, 1'b0);
    for (int n = 0; n < 10; n++)
      queue_sample(16'hFFFF, 1'b0);
    for (int n = 0; n < 5; n++)
      queue_sample(16'h0000, 1'b0);
    queue_random(300);
    wait_drained();

    // Zero gain and feedback: the history drains to silence.
    program_sections(18'h00000, 18'h00000, 18'h00000);
    queue_random(80);
    wait_drained();

    // Gain of one quarter with no feedback: a 1,2,1 moving average whose
    // DC gain is one, so most outputs stay in range.
    program_sections(18'h04000, 18'h00000, 18'h00000);
    queue_sample(16'hFFFF, 1'b1);
    queue_random(300);
    wait_drained();

    // Most positive then most negative gain, feedback at opposite extremes:
    // grows fast, wraps inside and clips at both ends.
    program_sections(18'h1FFFF, 18'h20000, 18'h1FFFF);
    queue_random(100);
    wait_drained();
    program_sections(18'h20000, 18'h1FFFF, 18'h20000);
    queue_random(100);
    wait_drained();

    // Every coefficient bit set: each field is minus one LSB.
    program_sections(18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    queue_random(100);
    wait_drained();

    // Independent random words in each section.
    for (int i = 0; i < SECTIONS; i++)
      write_coef(cfg_reg_e'(i), CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
    queue_random(200);
    wait_drained();

    // Back to the default low-pass, first with neither side idling, then
    // with idling again and a beat that waits for the output to drain.
    for (int i = 0; i < SECTIONS; i++)
      write_coef(cfg_reg_e'(i), COEF_RESET[i]);
    write_coef(REG_SPARE, '1);
    cfg_valid_i <= 1'b0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    queue_random(300);
    while (samples_taken != samples_queued)
      @(posedge clk_i);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    queue_random(250);
    queue_sample(next_level(), 1'b1);
    queue_random(250);
    wait_drained();

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // A run that hangs is stopped and reported as a failure.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/cbq_pkg.sv
rtl/cbq_ctrl.sv
rtl/cbq_datapath.sv
rtl/cascaded_biquad_lowpass.sv
verif/cascaded_biquad_lowpass_tb.sv
